// ===== hdl/etmm_pkg.sv =====
// Package: shared constants, types and polynomial helpers for the model matrix core.
`default_nettype none
package etmm_pkg;
   localparam int ANGLE_BITS_DEF = 16;
   localparam int TRIG_FRAC_BITS_DEF = 15;
   localparam int SCALE_W = 16;
   localparam int SHIFT_W = 32;
   localparam int ENTRY_W = 24;
   localparam int ZW = 31;  // Q30 phase, up to 1.0
   localparam int CW = 32;  // polynomial coefficient width
   localparam int NUM_HORNER = 6;  // C11..C1

   localparam logic [CW-1:0] POLY_C11 = 32'd3864;
   localparam logic [CW-1:0] POLY_C9 = 32'd172272;
   localparam logic [CW-1:0] POLY_C7 = 32'd5026995;
   localparam logic [CW-1:0] POLY_C5 = 32'd85569306;
   localparam logic [CW-1:0] POLY_C3 = 32'd693598669;
   localparam logic [CW-1:0] POLY_C1 = 32'd1686629713;

   localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = 24'sh7FFFFF;
   localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = -24'sh800000;

   // Coefficient that a Horner cell subtracts from; cell 0 loads C11.
   function automatic logic [CW-1:0] poly_coef(input int idx);
      logic [CW-1:0] c;
      begin
         unique case (idx)
            0: c = POLY_C11;
            1: c = POLY_C9;
            2: c = POLY_C7;
            3: c = POLY_C5;
            4: c = POLY_C3;
            default: c = POLY_C1;
         endcase
         return c;
      end
   endfunction

   // Trig work for one angle traveling through the cell chain.
   typedef struct packed {
      logic [ZW-1:0] z;
      logic [ZW-1:0] z2;
      logic [CW-1:0] t;
      logic          neg;
   } trig_lane_type;
endpackage
`default_nettype wire

// ===== hdl/etmm_trig_cell.sv =====
// Trig cell: one Horner step for six sine/cosine lanes, passing results onward.
`default_nettype none
module etmm_trig_cell #(
   parameter int IDX = 1
) (
   input  wire logic clock,
   input  wire logic adv,
   input  wire etmm_pkg::trig_lane_type lane_in [6],
   output etmm_pkg::trig_lane_type lane_out [6]
);
   import etmm_pkg::*;
   trig_lane_type lane_ff [6];
   trig_lane_type lane_in_c [6];
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         logic [ZW+CW-1:0] p;
         p = lane_in[i].z2 * lane_in[i].t;
         lane_in_c[i] = lane_in[i];
         lane_in_c[i].t = poly_coef(IDX) - p[ZW+CW-1-2:30];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) lane_ff <= lane_in_c;
   end
   assign lane_out = lane_ff;
endmodule
`default_nettype wire

// ===== hdl/etmm_mix_cell.sv =====
// Mix cell: one multiply stage for the matrix terms, floor shift by F.
`default_nettype none
module etmm_mix_cell #(
   parameter int F = 15,
   parameter int N = 1
) (
   input  wire logic clock,
   input  wire logic adv,
   input  wire logic signed [F+1:0] a_in [N],
   input  wire logic signed [F+1:0] b_in [N],
   output logic signed [F+1:0] p_out [N]
);
   import etmm_pkg::*;
   logic signed [F+1:0] p_ff [N];
   logic signed [F+1:0] p_in [N];
   always_comb begin
      for (int i = 0; i < N; i++) begin
         logic signed [2*F+3:0] m;
         m = a_in[i] * b_in[i];
         p_in[i] = m[2*F+1:F]; // arithmetic floor
      end
   end
   always_ff @(posedge clock) begin
      if (adv) p_ff <= p_in;
   end
   assign p_out = p_ff;
endmodule
`default_nettype wire

// ===== hdl/euler_trs_model_matrix_core.sv =====
// Top level: pipelined TRS model matrix builder with sine polynomial cell chain.
`default_nettype none
// One request enters per cycle while the output is not stalled. The pipeline is
// made of a fold stage and the chain of five trig cells (one per Horner step of
// the sine polynomial), then a sine finishing stage, two multiply stages, a sum
// stage and a scale/saturate stage. A stall on the result side freezes the whole
// pipeline, so req_stall follows rsp_stall only when the output holds a result.
// Translation passes through unchanged.
module euler_trs_model_matrix_core #(
   parameter int ANGLE_BITS = etmm_pkg::ANGLE_BITS_DEF,
   parameter int TRIG_FRAC_BITS = etmm_pkg::TRIG_FRAC_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  wire logic [15:0] req_yaw_angle,
   input  wire logic [15:0] req_pitch_angle,
   input  wire logic [15:0] req_roll_angle,
   input  wire logic signed [etmm_pkg::SCALE_W-1:0] req_scale_x,
   input  wire logic signed [etmm_pkg::SCALE_W-1:0] req_scale_y,
   input  wire logic signed [etmm_pkg::SCALE_W-1:0] req_scale_z,
   input  wire logic signed [etmm_pkg::SHIFT_W-1:0] req_shift_x,
   input  wire logic signed [etmm_pkg::SHIFT_W-1:0] req_shift_y,
   input  wire logic signed [etmm_pkg::SHIFT_W-1:0] req_shift_z,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output logic signed [etmm_pkg::ENTRY_W-1:0] rsp_col0_row0,
   output logic signed [etmm_pkg::ENTRY_W-1:0] rsp_col0_row1,
   output logic signed [etmm_pkg::ENTRY_W-1:0] rsp_col0_row2,
   output logic signed [etmm_pkg::ENTRY_W-1:0] rsp_col1_row0,
   output logic signed [etmm_pkg::ENTRY_W-1:0] rsp_col1_row1,
   output logic signed [etmm_pkg::ENTRY_W-1:0] rsp_col1_row2,
   output logic signed [etmm_pkg::ENTRY_W-1:0] rsp_col2_row0,
   output logic signed [etmm_pkg::ENTRY_W-1:0] rsp_col2_row1,
   output logic signed [etmm_pkg::ENTRY_W-1:0] rsp_col2_row2,
   output logic signed [etmm_pkg::SHIFT_W-1:0] rsp_col3_row0,
   output logic signed [etmm_pkg::SHIFT_W-1:0] rsp_col3_row1,
   output logic signed [etmm_pkg::SHIFT_W-1:0] rsp_col3_row2
);
   import etmm_pkg::*;
   localparam int F = TRIG_FRAC_BITS;
   localparam int TW = F + 2;       // signed trig and product width
   localparam int SUMW = F + 3;     // sum of two products
   localparam int NST = NUM_HORNER + 5; // total stages
   localparam int QB = ANGLE_BITS - 2;
   localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << QB;

   typedef struct packed {
      logic signed [SCALE_W-1:0] sx;
      logic signed [SCALE_W-1:0] sy;
      logic signed [SCALE_W-1:0] sz;
      logic signed [SHIFT_W-1:0] tx;
      logic signed [SHIFT_W-1:0] ty;
      logic signed [SHIFT_W-1:0] tz;
   } side_type;

   // valid pipeline
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;
   logic adv;
   assign adv = !(vld_ff[NST-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[NST-1];
   always_comb begin
      vld_in = {vld_ff[NST-2:0], req_valid};
   end
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= vld_in;
   end

   side_type side_ff [NST];
   side_type side_in [NST];
   always_comb begin
      side_in[0] = '{req_scale_x, req_scale_y, req_scale_z,
                     req_shift_x, req_shift_y, req_shift_z};
      for (int i = 1; i < NST; i++) side_in[i] = side_ff[i-1];
   end
   always_ff @(posedge clock) begin
      if (adv) side_ff <= side_in;
   end

   // stage 0: fold angles, z and z^2
   // lanes: 0 s1,1 c1,2 s2,3 c2,4 s3,5 c3
   logic [ANGLE_BITS-1:0] ang [6];
   trig_lane_type lane0_in [6];
   trig_lane_type lane0_ff [6];
   always_comb begin
      ang[0] = req_yaw_angle[ANGLE_BITS-1:0];
      ang[1] = req_yaw_angle[ANGLE_BITS-1:0] + QUARTER;
      ang[2] = req_pitch_angle[ANGLE_BITS-1:0];
      ang[3] = req_pitch_angle[ANGLE_BITS-1:0] + QUARTER;
      ang[4] = req_roll_angle[ANGLE_BITS-1:0];
      ang[5] = req_roll_angle[ANGLE_BITS-1:0] + QUARTER;
      for (int i = 0; i < 6; i++) begin
         logic [QB:0] r;
         logic [ZW-1:0] z;
         logic [2*ZW-1:0] zz;
         r = {1'b0, ang[i][QB-1:0]};
         if (ang[i][QB]) r = {1'b1, {QB{1'b0}}} - r;
         z = ZW'(r) << (32 - ANGLE_BITS);
         zz = z * z;
         lane0_in[i].z = z;
         lane0_in[i].z2 = zz[ZW+29:30];
         lane0_in[i].t = POLY_C11;
         lane0_in[i].neg = ang[i][QB+1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) lane0_ff <= lane0_in;
   end

   trig_lane_type chain [NUM_HORNER][6];
   assign chain[0] = lane0_ff;
   for (genvar k = 1; k < NUM_HORNER; k++) begin : g_horner
      etmm_trig_cell #(.IDX(k)) u_cell (
         .clock(clock), .adv(adv), .lane_in(chain[k-1]), .lane_out(chain[k]));
   end

   // final sine stage: z*t, shift, clamp, sign
   logic signed [TW-1:0] trig_in [6];
   logic signed [TW-1:0] trig_ff [6];
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         logic [ZW+CW-1:0] p;
         logic [ZW+CW-1:0] s;
         logic [TW-1:0] m;
         p = chain[NUM_HORNER-1][i].z * chain[NUM_HORNER-1][i].t;
         s = (p >> 30) >> (30 - F);
         if (s > ((ZW+CW)'(1) << F) - 1) m = TW'((1 << F) - 1);
         else m = TW'(s);
         trig_in[i] = chain[NUM_HORNER-1][i].neg ? -$signed(m) : $signed(m);
      end
   end
   always_ff @(posedge clock) begin
      if (adv) trig_ff <= trig_in;
   end

   // mix stage A: first products (s1,c1,s2,c2,s3,c3 = 0..5)
   localparam int NA = 9;
   logic signed [TW-1:0] a_a [NA];
   logic signed [TW-1:0] a_b [NA];
   logic signed [TW-1:0] pa [NA];
   always_comb begin
      a_a[0] = trig_ff[1]; a_b[0] = trig_ff[5]; // c1c3
      a_a[1] = trig_ff[0]; a_b[1] = trig_ff[2]; // s1s2
      a_a[2] = trig_ff[3]; a_b[2] = trig_ff[4]; // c2s3
      a_a[3] = trig_ff[1]; a_b[3] = trig_ff[2]; // c1s2
      a_a[4] = trig_ff[5]; a_b[4] = trig_ff[0]; // c3s1
      a_a[5] = trig_ff[1]; a_b[5] = trig_ff[4]; // c1s3
      a_a[6] = trig_ff[3]; a_b[6] = trig_ff[5]; // c2c3
      a_a[7] = trig_ff[0]; a_b[7] = trig_ff[4]; // s1s3
      a_a[8] = trig_ff[3]; a_b[8] = trig_ff[0]; // c2s1
   end
   etmm_mix_cell #(.F(F), .N(NA)) u_mix_a (
      .clock(clock), .adv(adv), .a_in(a_a), .b_in(a_b), .p_out(pa));
   // carry raw trig needed later
   logic signed [TW-1:0] trig_d1 [6];
   always_ff @(posedge clock) begin
      if (adv) trig_d1 <= trig_ff;
   end

   // mix stage B: triple products, the c1c2 product and pass-through of pairs
   localparam int NB = 12;
   logic signed [TW-1:0] b_a [NB];
   logic signed [TW-1:0] b_b [NB];
   logic signed [TW-1:0] pb [NB];
   localparam logic signed [TW-1:0] ONE = TW'(1) <<< F;
   always_comb begin
      b_a[0] = pa[1]; b_b[0] = trig_d1[4]; // s1s2*s3
      b_a[1] = pa[3]; b_b[1] = trig_d1[4]; // c1s2*s3
      b_a[2] = pa[4]; b_b[2] = trig_d1[2]; // c3s1*s2
      b_a[3] = pa[0]; b_b[3] = trig_d1[2]; // c1c3*s2
      b_a[4] = trig_d1[1]; b_b[4] = trig_d1[3]; // c1c2
      // pass by multiplying with exact one (floor of x*2^F/2^F = x)
      b_a[5] = pa[0]; b_b[5] = ONE;
      b_a[6] = pa[2]; b_b[6] = ONE;
      b_a[7] = pa[4]; b_b[7] = ONE;
      b_a[8] = pa[5]; b_b[8] = ONE;
      b_a[9] = pa[6]; b_b[9] = ONE;
      b_a[10] = pa[7]; b_b[10] = ONE;
      b_a[11] = pa[8]; b_b[11] = ONE;
   end
   etmm_mix_cell #(.F(F), .N(NB)) u_mix_b (
      .clock(clock), .adv(adv), .a_in(b_a), .b_in(b_b), .p_out(pb));
   logic signed [TW-1:0] ns2_ff;
   always_ff @(posedge clock) begin
      if (adv) ns2_ff <= trig_d1[2];
   end

   // sum stage
   logic signed [SUMW-1:0] sum_in [9];
   logic signed [SUMW-1:0] sum_ff [9];
   always_comb begin
      sum_in[0] = SUMW'(pb[5]) + SUMW'(pb[0]);
      sum_in[1] = SUMW'(pb[6]);
      sum_in[2] = SUMW'(pb[1]) - SUMW'(pb[7]);
      sum_in[3] = SUMW'(pb[2]) - SUMW'(pb[8]);
      sum_in[4] = SUMW'(pb[9]);
      sum_in[5] = SUMW'(pb[3]) + SUMW'(pb[10]);
      sum_in[6] = SUMW'(pb[11]);
      sum_in[7] = -SUMW'(ns2_ff);
      sum_in[8] = SUMW'(pb[4]);
   end
   always_ff @(posedge clock) begin
      if (adv) sum_ff <= sum_in;
   end

   // scale, floor shift, saturate; this is the output register
   localparam int PW = SCALE_W + SUMW;
   logic signed [ENTRY_W-1:0] ent_in [9];
   logic signed [ENTRY_W-1:0] ent_ff [9];
   side_type so;
   assign so = side_ff[NST-2];
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         logic signed [SCALE_W-1:0] sc;
         logic signed [PW-1:0] p;
         logic signed [PW-1:0] v;
         sc = (i < 3) ? so.sx : (i < 6) ? so.sy : so.sz;
         p = PW'(sc) * PW'(sum_ff[i]);
         v = p >>> (F - 7);
         if (v > PW'(ENTRY_MAX)) ent_in[i] = ENTRY_MAX;
         else if (v < PW'(ENTRY_MIN)) ent_in[i] = ENTRY_MIN;
         else ent_in[i] = v[ENTRY_W-1:0];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) ent_ff <= ent_in;
   end

   assign rsp_col0_row0 = ent_ff[0];
   assign rsp_col0_row1 = ent_ff[1];
   assign rsp_col0_row2 = ent_ff[2];
   assign rsp_col1_row0 = ent_ff[3];
   assign rsp_col1_row1 = ent_ff[4];
   assign rsp_col1_row2 = ent_ff[5];
   assign rsp_col2_row0 = ent_ff[6];
   assign rsp_col2_row1 = ent_ff[7];
   assign rsp_col2_row2 = ent_ff[8];
   assign rsp_col3_row0 = side_ff[NST-1].tx;
   assign rsp_col3_row1 = side_ff[NST-1].ty;
   assign rsp_col3_row2 = side_ff[NST-1].tz;

   // a stalled result must hold
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_col0_row0))
      else $error("result dropped under stall");
   // an accepted request shows up in the first valid stage
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> ##1 vld_ff[0])
      else $error("valid lost at entry");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without cause");
endmodule
`default_nettype wire
